// ===== src/bale_pkg.sv =====
// bale_pkg: sizes, operation and status codes, sequencer states and the
// structs shared by the array list engine modules; depends on nothing
package bale_pkg;

    localparam int MAX_ENTRIES = 1024;
    localparam int AW          = $clog2(MAX_ENTRIES);
    localparam int LW          = $clog2(MAX_ENTRIES + 1);

    localparam int FUNC_W    = 3;
    localparam int POS_W     = 10;
    localparam int DATA_W    = 32;
    localparam int STAT_W    = 2;
    localparam int CAP_W     = 11;
    localparam int LEN_OUT_W = 11;

    // common widths for comparing the length against position and capacity
    localparam int PCMP_W = (LW > POS_W) ? LW : POS_W;
    localparam int CCMP_W = (LW > CAP_W) ? LW : CAP_W;

    localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;

    typedef enum logic [FUNC_W-1:0] {
        FN_READ      = 3'd0,
        FN_OVERWRITE = 3'd1,
        FN_APPEND    = 3'd2,
        FN_INSERT    = 3'd3,
        FN_DELETE    = 3'd4
    } func_t;

    typedef enum logic [STAT_W-1:0] {
        ST_DONE  = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_SHIFT,
        S_PUT
    } state_t;

    typedef struct packed {
        logic              we;
        logic [AW-1:0]     waddr;
        logic [DATA_W-1:0] wdata;
        logic              re;
        logic [AW-1:0]     raddr;
    } ram_req_t;

    typedef struct packed {
        logic              load;
        status_t           status;
        logic [DATA_W-1:0] rdata;
        logic [LW-1:0]     length;
    } result_t;

    typedef struct packed {
        logic          busy;
        logic [LW-1:0] length;
    } seq_stat_t;

endpackage

// ===== src/bale_ram.sv =====
// bale_ram: generic single write port, single read port memory with
// registered read data; no package dependency
module bale_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/bale_seq.sv =====
// bale_seq: request decode, length register and the sequencer that moves
// entries one per cycle through the store with a shared +/-1 unit; uses bale_pkg
module bale_seq (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [bale_pkg::FUNC_W-1:0]   func,
    input  logic [bale_pkg::POS_W-1:0]    position,
    input  logic [bale_pkg::DATA_W-1:0]   item_value,
    input  logic [bale_pkg::CAP_W-1:0]    cap,
    input  logic                          out_free,
    input  logic [bale_pkg::DATA_W-1:0]   ram_rdata,
    output bale_pkg::ram_req_t            ram_req,
    output bale_pkg::result_t             res,
    output bale_pkg::seq_stat_t           seq_stat
);

    import bale_pkg::*;

    state_t            state_reg, state_next;
    logic [LW-1:0]     len_reg, len_next;
    logic [AW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [AW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]     pos_reg, pos_next;
    logic [DATA_W-1:0] val_reg, val_next;
    logic              ins_reg, ins_next;

    // shared step unit
    logic [LW-1:0] alu_a, alu_y;
    logic          alu_down;

    logic accept, pos_lt_len, pos_eq_len, full, last;

    assign alu_y = alu_down ? (alu_a - LW'(1)) : (alu_a + LW'(1));

    assign in_stall   = (state_reg != S_IDLE) || !out_free;
    assign accept     = in_valid && !in_stall;
    assign pos_lt_len = PCMP_W'(position) < PCMP_W'(len_reg);
    assign pos_eq_len = PCMP_W'(position) == PCMP_W'(len_reg);
    assign full       = (CCMP_W'(len_reg) >= CCMP_W'(cap))
                        || (len_reg == LW'(MAX_ENTRIES));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            len_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            len_reg   <= len_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_ptr_reg <= rd_ptr_next;
        wr_ptr_reg <= wr_ptr_next;
        pos_reg    <= pos_next;
        val_reg    <= val_next;
        ins_reg    <= ins_next;
    end

    // operand and direction of the step unit
    always_comb
    begin
        alu_a    = len_reg;
        alu_down = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (func == FN_DELETE)
                begin
                    alu_a = LW'(position);
                end
                // insert inside the list starts the shift from the top entry
                alu_down = (func == FN_INSERT) && pos_lt_len;
            end
            S_SHIFT:
            begin
                alu_a    = LW'(rd_ptr_reg);
                alu_down = ins_reg;
            end
            S_PUT:
            begin
                alu_down = !ins_reg;
            end
            default:
            begin
                alu_down = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next    = state_reg;
        len_next      = len_reg;
        rd_ptr_next   = rd_ptr_reg;
        wr_ptr_next   = wr_ptr_reg;
        pos_next      = pos_reg;
        val_next      = val_reg;
        ins_next      = ins_reg;
        last          = 1'b0;
        ram_req       = '0;
        res.load      = 1'b0;
        res.status    = ST_DONE;
        res.rdata     = '0;
        res.length    = len_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    pos_next = AW'(position);
                    val_next = item_value;
                    case (func_t'(func))
                        FN_READ:
                        begin
                            if (pos_lt_len)
                            begin
                                ram_req.re    = 1'b1;
                                ram_req.raddr = AW'(position);
                                state_next    = S_READ;
                            end
                            else
                            begin
                                res.load   = 1'b1;
                                res.status = ST_RANGE;
                            end
                        end
                        FN_OVERWRITE:
                        begin
                            res.load = 1'b1;
                            if (pos_lt_len)
                            begin
                                ram_req.we    = 1'b1;
                                ram_req.waddr = AW'(position);
                                ram_req.wdata = item_value;
                            end
                            else
                            begin
                                res.status = ST_RANGE;
                            end
                        end
                        FN_APPEND:
                        begin
                            res.load = 1'b1;
                            if (full)
                            begin
                                res.status = ST_FULL;
                            end
                            else
                            begin
                                ram_req.we    = 1'b1;
                                ram_req.waddr = AW'(len_reg);
                                ram_req.wdata = item_value;
                                len_next      = alu_y;
                                res.length    = alu_y;
                            end
                        end
                        FN_INSERT:
                        begin
                            if (full)
                            begin
                                res.load   = 1'b1;
                                res.status = ST_FULL;
                            end
                            else if (!(pos_lt_len || pos_eq_len))
                            begin
                                res.load   = 1'b1;
                                res.status = ST_RANGE;
                            end
                            else if (pos_eq_len)
                            begin
                                // insert at the end is an append
                                res.load      = 1'b1;
                                ram_req.we    = 1'b1;
                                ram_req.waddr = AW'(len_reg);
                                ram_req.wdata = item_value;
                                len_next      = alu_y;
                                res.length    = alu_y;
                            end
                            else
                            begin
                                ram_req.re    = 1'b1;
                                ram_req.raddr = alu_y[AW-1:0];
                                rd_ptr_next   = alu_y[AW-1:0];
                                wr_ptr_next   = AW'(len_reg);
                                ins_next      = 1'b1;
                                state_next    = S_SHIFT;
                            end
                        end
                        FN_DELETE:
                        begin
                            if (!pos_lt_len)
                            begin
                                res.load   = 1'b1;
                                res.status = ST_RANGE;
                            end
                            else
                            begin
                                ins_next = 1'b0;
                                if (alu_y == len_reg)
                                begin
                                    // last entry: nothing to move
                                    state_next = S_PUT;
                                end
                                else
                                begin
                                    ram_req.re    = 1'b1;
                                    ram_req.raddr = alu_y[AW-1:0];
                                    rd_ptr_next   = alu_y[AW-1:0];
                                    wr_ptr_next   = AW'(position);
                                    state_next    = S_SHIFT;
                                end
                            end
                        end
                        default:
                        begin
                            res.load   = 1'b1;
                            res.status = ST_RANGE;
                        end
                    endcase
                end
            end
            S_READ:
            begin
                res.load   = 1'b1;
                res.rdata  = ram_rdata;
                state_next = S_IDLE;
            end
            S_SHIFT:
            begin
                // write the entry read last cycle, fetch the next one
                last          = ins_reg ? (rd_ptr_reg == pos_reg) : (alu_y == len_reg);
                ram_req.we    = 1'b1;
                ram_req.waddr = wr_ptr_reg;
                ram_req.wdata = ram_rdata;
                if (last)
                begin
                    state_next = S_PUT;
                end
                else
                begin
                    ram_req.re    = 1'b1;
                    ram_req.raddr = alu_y[AW-1:0];
                    rd_ptr_next   = alu_y[AW-1:0];
                    wr_ptr_next   = rd_ptr_reg;
                end
            end
            S_PUT:
            begin
                ram_req.we    = ins_reg;
                ram_req.waddr = pos_reg;
                ram_req.wdata = val_reg;
                len_next      = alu_y;
                res.load      = 1'b1;
                res.length    = alu_y;
                state_next    = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign seq_stat.busy   = (state_reg != S_IDLE);
    assign seq_stat.length = len_reg;

endmodule

// ===== src/bounded_array_list_engine_top.sv =====
// bounded_array_list_engine_top: capacity register, result register and the
// wiring of sequencer and entry store; uses bale_pkg, bale_seq, bale_ram
//
// Ordered list of up to 1024 signed 32-bit entries in a single-port-write,
// single-port-read store. One request is taken at a time and gives one result
// beat. Rejected requests, overwrite and append (and insert at the end) give
// their result on acceptance; read waits for the store read data. Insert and
// delete move every shifted entry through the one store write port at one
// per cycle, then finish in a put step, as does delete of the last entry.
// The store needs no clearing after reset. The user must write capacity
// through cfg_we/cfg_wdata while the block is idle; the block does not check.
module bounded_array_list_engine_top (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [bale_pkg::CAP_W-1:0]        cfg_wdata,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [bale_pkg::FUNC_W-1:0]       func,
    input  logic [bale_pkg::POS_W-1:0]        position,
    input  logic signed [bale_pkg::DATA_W-1:0] item_value,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [bale_pkg::STAT_W-1:0]       status,
    output logic signed [bale_pkg::DATA_W-1:0] read_data,
    output logic [bale_pkg::LEN_OUT_W-1:0]    length_now
);

    import bale_pkg::*;

    logic [CAP_W-1:0]     cap_reg;
    logic                 out_valid_reg;
    logic [STAT_W-1:0]    status_reg;
    logic [DATA_W-1:0]    rdata_reg;
    logic [LEN_OUT_W-1:0] length_reg;

    logic              out_free;
    logic [DATA_W-1:0] ram_rdata;
    ram_req_t          ram_req;
    result_t           res;
    seq_stat_t         seq_stat;

    assign out_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= CAP_RESET;
        end
        else if (cfg_we)
        begin
            cap_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res.load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res.load)
        begin
            status_reg <= STAT_W'(res.status);
            rdata_reg  <= res.rdata;
            length_reg <= LEN_OUT_W'(res.length);
        end
    end

    bale_seq u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .func       (func),
        .position   (position),
        .item_value (item_value),
        .cap        (cap_reg),
        .out_free   (out_free),
        .ram_rdata  (ram_rdata),
        .ram_req    (ram_req),
        .res        (res),
        .seq_stat   (seq_stat)
    );

    bale_ram #(
        .DEPTH (MAX_ENTRIES),
        .WIDTH (DATA_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_req.we),
        .waddr (ram_req.waddr),
        .wdata (ram_req.wdata),
        .re    (ram_req.re),
        .raddr (ram_req.raddr),
        .rdata (ram_rdata)
    );

    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign read_data  = rdata_reg;
    assign length_now = length_reg;

    // a result is only loaded into a free output register
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        res.load |-> out_free)
        else $error("result loaded over a pending beat");

    // length moves only together with a result
    a_len_with_result: assert property (@(posedge clk) disable iff (!rst_n)
        !res.load |=> (seq_stat.length == $past(seq_stat.length)))
        else $error("length changed without a result");

    // no new request while the sequencer is busy
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        seq_stat.busy |-> in_stall)
        else $error("request taken while busy");

    // the list never grows past the store
    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        res.load |-> (res.length <= LW'(MAX_ENTRIES)))
        else $error("length beyond store depth");

endmodule

// ===== tb/sv/tb.sv =====
// tb: self-checking bench for bounded_array_list_engine_top; keeps its own copy of
// the list and capacity, predicts every result beat and compares field by field
// depends on bale_pkg and bounded_array_list_engine_top
module tb;

    import bale_pkg::*;

    localparam int QUIET_LIMIT = 20000;
    localparam int LONG_HOLD   = 400;
    localparam logic [FUNC_W-1:0] FN_LAST_CODE = '1;

    typedef struct {
        status_t                  st;
        logic signed [DATA_W-1:0] data;
        logic [LEN_OUT_W-1:0]     len;
    } list_reply_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic [CAP_W-1:0] cfg_wdata;
    logic in_valid;
    logic in_stall;
    logic [FUNC_W-1:0] func;
    logic [POS_W-1:0] position;
    logic signed [DATA_W-1:0] item_value;
    logic out_valid;
    logic out_stall;
    logic [STAT_W-1:0] status;
    logic signed [DATA_W-1:0] read_data;
    logic [LEN_OUT_W-1:0] length_now;

    // predicted list contents and settings
    logic signed [DATA_W-1:0] list_mem [0:MAX_ENTRIES-1];
    int list_len;
    logic [CAP_W-1:0] list_cap;
    list_reply_t pending_replies[$];

    int mismatches = 0;
    int quiet_cycles = 0;
    bit in_gaps_en;
    bit out_stall_en;
    int unsigned hold_cycles = 0;

    always #1 clk = ~clk;

    bounded_array_list_engine_top u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .func       (func),
        .position   (position),
        .item_value (item_value),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .status     (status),
        .read_data  (read_data),
        .length_now (length_now)
    );

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic signed [DATA_W-1:0] rand_value();
        case ($urandom_range(0, 7))
            0: return 32'sh8000_0000;
            1: return 32'sh7fff_ffff;
            2: return '0;
            3: return '1;
            default: return $urandom;
        endcase
    endfunction

    // applies one request to the list copy and queues the reply it should give
    function automatic void predict_reply(input logic [FUNC_W-1:0] f,
                                          input logic [POS_W-1:0] p,
                                          input logic signed [DATA_W-1:0] v);
        list_reply_t rep;
        int lim;
        int pos;
        lim = (list_cap > MAX_ENTRIES) ? MAX_ENTRIES : int'(list_cap);
        pos = p;
        rep.st = ST_DONE;
        rep.data = '0;
        case (f)
            FN_READ:
                if (pos >= list_len)
                    rep.st = ST_RANGE;
                else
                    rep.data = list_mem[pos];
            FN_OVERWRITE:
                if (pos >= list_len)
                    rep.st = ST_RANGE;
                else
                    list_mem[pos] = v;
            FN_APPEND:
                if (list_len >= lim)
                    rep.st = ST_FULL;
                else
                begin
                    list_mem[list_len] = v;
                    list_len++;
                end
            FN_INSERT:
                // full wins over a bad position
                if (list_len >= lim)
                    rep.st = ST_FULL;
                else if (pos > list_len)
                    rep.st = ST_RANGE;
                else
                begin
                    for (int i = list_len; i > pos; i--)
                        list_mem[i] = list_mem[i-1];
                    list_mem[pos] = v;
                    list_len++;
                end
            FN_DELETE:
                if (pos >= list_len)
                    rep.st = ST_RANGE;
                else
                begin
                    for (int i = pos; i + 1 < list_len; i++)
                        list_mem[i] = list_mem[i+1];
                    list_len--;
                end
            default:
                rep.st = ST_RANGE;
        endcase
        rep.len = LEN_OUT_W'(list_len);
        pending_replies.push_back(rep);
    endfunction

    // offers one request and holds it until accepted
    task automatic send_request(input logic [FUNC_W-1:0] f, input logic [POS_W-1:0] p,
                                input logic signed [DATA_W-1:0] v);
        int unsigned gap;
        in_valid <= 1'b1;
        func <= f;
        position <= p;
        item_value <= v;
        do
            @(posedge clk);
        while (!(in_valid && !in_stall));
        predict_reply(f, p, v);
        gap = in_gaps_en ? pick_gap() : 0;
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_replies.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_capacity(input logic [CAP_W-1:0] cap);
        wait_drained();
        cfg_we <= 1'b1;
        cfg_wdata <= cap;
        @(posedge clk);
        cfg_we <= 1'b0;
        list_cap = cap;
    endtask

    task automatic send_random_op();
        int unsigned r;
        logic [FUNC_W-1:0] f;
        logic [POS_W-1:0] p;
        r = $urandom_range(0, 99);
        if (r < 4)
        begin
            // noise: any code, any position
            f = FUNC_W'($urandom_range(0, FN_LAST_CODE));
            p = POS_W'($urandom);
        end
        else
        begin
            r = $urandom_range(0, 99);
            if (r < 18)
                f = FN_READ;
            else if (r < 32)
                f = FN_OVERWRITE;
            else if (r < 54)
                f = FN_APPEND;
            else if (r < 76)
                f = FN_INSERT;
            else
                f = FN_DELETE;
            r = $urandom_range(0, 99);
            if (r < 85)
            begin
                if (f == FN_INSERT)
                    p = POS_W'($urandom_range(0, list_len));
                else
                    p = (list_len == 0) ? '0 : POS_W'($urandom_range(0, list_len - 1));
            end
            else if (r < 93)
                // first position past the valid range
                p = (f == FN_INSERT) ? POS_W'(list_len + 1) : POS_W'(list_len);
            else
                p = POS_W'($urandom);
        end
        send_request(f, p, rand_value());
    endtask

    task automatic test_empty_list();
        send_request(FN_READ, '0, '0);
        send_request(FN_OVERWRITE, '0, 32'sd5);
        send_request(FN_DELETE, '0, '0);
        send_request(FN_INSERT, 10'd1, 32'sd7);
        send_request(FN_READ, 10'd1023, '0);
        for (int c = FN_DELETE + 1; c <= FN_LAST_CODE; c++)
            send_request(FUNC_W'(c), '0, 32'sd3);
    endtask

    task automatic test_basic_ops();
        send_request(FN_INSERT, '0, 32'sd11);
        send_request(FN_APPEND, 10'd1023, 32'sh8000_0000);
        send_request(FN_APPEND, '0, 32'sh7fff_ffff);
        send_request(FN_INSERT, 10'd1, -32'sd1);
        send_request(FN_READ, 10'd1, '0);
        send_request(FN_READ, 10'd2, '0);
        send_request(FN_OVERWRITE, 10'd2, 32'sh5a5a_5a5a);
        send_request(FN_READ, 10'd2, '0);
        send_request(FN_INSERT, 10'd4, 32'sd99);
        send_request(FN_DELETE, 10'd1, '0);
        send_request(FN_DELETE, 10'd3, '0);
        send_request(FN_READ, 10'd3, '0);
        send_request(FN_OVERWRITE, 10'd3, 32'sd1);
    endtask

    task automatic test_capacity_limits();
        set_capacity('0);
        send_request(FN_APPEND, '0, 32'sd4);
        send_request(FN_INSERT, 10'd1000, 32'sd4);
        // capacity below the length keeps what is stored
        set_capacity(11'd2);
        send_request(FN_APPEND, '0, 32'sd4);
        send_request(FN_READ, 10'd2, '0);
        set_capacity(11'd4);
        send_request(FN_INSERT, 10'd1, 32'sd21);
        send_request(FN_APPEND, '0, 32'sd22);
    endtask

    task automatic test_random_traffic();
        logic [CAP_W-1:0] cap;
        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph)
                0: cap = 11'd1;
                1: cap = 11'd3;
                2: cap = CAP_RESET;
                3: cap = 11'd8;
                4: cap = CAP_W'($urandom_range(1, 200));
                5: cap = 11'd0;
                6: cap = 11'd40;
                default: cap = CAP_W'($urandom_range(1, 1024));
            endcase
            set_capacity(cap);
            in_gaps_en = (ph % 3 != 2);
            out_stall_en = (ph % 3 != 2);
            for (int n = 0; n < 70; n++)
            begin
                // receiver stops for a long time while requests keep coming
                if (ph == 2 && n == 10)
                    hold_cycles = LONG_HOLD;
                // sender stops until every reply is back
                if (ph == 4 && n == 35)
                    wait_drained();
                send_random_op();
            end
        end
        in_gaps_en = 1'b1;
        out_stall_en = 1'b1;
    endtask

    task automatic test_cap_above_store();
        // all-ones capacity is above the store size
        set_capacity('1);
        in_gaps_en = 1'b0;
        send_request(FN_APPEND, '0, 32'sd1);
        send_request(FN_INSERT, '0, 32'sh8000_0000);
        send_request(FN_READ, '0, '0);
        send_request(FN_DELETE, '0, '0);
        set_capacity(CAP_RESET);
        send_request(FN_APPEND, '0, 32'sd2);
        in_gaps_en = 1'b1;
    endtask

    // receiver side: random stalls plus the long hold on request
    initial
    begin
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_cycles != 0)
            begin
                out_stall <= 1'b1;
                repeat (hold_cycles) @(posedge clk);
                hold_cycles = 0;
                out_stall <= 1'b0;
            end
            else if (out_stall_en && $urandom_range(0, 2) == 0)
            begin
                out_stall <= 1'b1;
                repeat (pick_gap() + 1) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin : check_replies
        list_reply_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_replies.size() == 0)
            begin
                $error("result beat with nothing pending: status %0d length_now %0d",
                       status, length_now);
                mismatches++;
            end
            else
            begin
                want = pending_replies.pop_front();
                if (status !== want.st)
                begin
                    $error("status: expected %0d, got %0d", want.st, status);
                    mismatches++;
                end
                if (read_data !== want.data)
                begin
                    $error("read_data: expected %0d, got %0d", want.data, read_data);
                    mismatches++;
                end
                if (length_now !== want.len)
                begin
                    $error("length_now: expected %0d, got %0d", want.len, length_now);
                    mismatches++;
                end
            end
        end
    end

    // ends the run if neither channel moves a beat for too long
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == QUIET_LIMIT)
            begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_wdata <= '0;
        in_valid <= 1'b0;
        func <= '0;
        position <= '0;
        item_value <= '0;
        in_gaps_en = 1'b1;
        out_stall_en = 1'b1;
        list_len = 0;
        list_cap = CAP_RESET;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        test_empty_list();
        test_basic_ops();
        test_capacity_limits();
        test_random_traffic();
        test_cap_above_store();
        wait_drained();
        repeat (20) @(posedge clk);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
